### hdl/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned CountW  = 18;
  localparam int unsigned AddrW   = 29;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgW    = 18;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_INIT  = 3'd1,
    STAT_ZERO_CNT  = 3'd2,
    STAT_NO_SPACE  = 3'd3,
    STAT_UNALIGNED = 3'd4,
    STAT_RANGE     = 3'd5,
    STAT_DBL_FREE  = 3'd6,
    STAT_RSVD      = 3'd7
  } status_e;

  localparam logic [CfgIdxW-1:0] REG_TOTAL    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_RESERVED = 1'd1;

  localparam logic [CfgW-1:0] TotalReset    = 18'd131072;
  localparam logic [CfgW-1:0] ReservedReset = 18'd256;

  typedef struct packed {
    cmd_e               command;
    logic [AddrW-1:0]   address;
    logic [CountW-1:0]  count;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [AddrW-1:0]   result_address;
    logic [CountW-1:0]  free_count;
    logic [CountW-1:0]  used_count;
    logic [CountW-1:0]  page_total;
  } rsp_t;

endpackage

### hdl/bpa_map_ram.sv
module bpa_map_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hdl/bitmap_page_allocator.sv
// channel   dir  handshake                payload
// request   in   in_valid_i / in_ready_o  in_req_i   (command, address, count)
// response  out  out_valid_o / out_ready_i out_rsp_o (status, address, counts)
// config    in   cfg_we_i                 cfg_idx_i, cfg_data_i
//
// init sweeps the whole map, one word a cycle.
// allocate walks pages from the lowest free hint one a cycle, except while a map
// word is fetched, then marks the run and advances the hint the same way.
// free walks count pages one a cycle, except while a map word is fetched.
// one request at a time; the map's one read port and one write port set the pace.
// the map is only read after an init, so reset clears control state only.
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGE_COUNT = 131072,
  parameter int unsigned PAGE_BYTES     = 4096,
  parameter int unsigned MAP_WORD_BITS  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bpa_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bpa_pkg::rsp_t              out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [bpa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpa_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int unsigned MapWords = (MAX_PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WidxW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BitW     = $clog2(MAP_WORD_BITS);
  localparam int unsigned CntW     = $clog2(MAX_PAGE_COUNT + 1);
  localparam int unsigned PgSh     = $clog2(PAGE_BYTES);
  localparam int unsigned FirstW   = bpa_pkg::AddrW - PgSh;
  localparam int unsigned PtrW     = ((FirstW > CntW) ? FirstW : CntW) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_MARK, S_HINT, S_FREE, S_LOAD, S_CAPT, S_FLUSH, S_DONE
  } state_e;

  state_e state_q, ret_q;

  logic [bpa_pkg::CfgW-1:0]   total_cfg_q, resv_cfg_q;
  logic                       ready_q;
  logic [CntW-1:0]            active_q, free_q, hint_q, res_q, run_q;
  logic [PtrW-1:0]            p_q, end_q;
  logic [bpa_pkg::CountW-1:0] cnt_q, rem_q;
  bpa_pkg::status_e           stat_q;
  logic [bpa_pkg::AddrW-1:0]  addr_q;
  logic [MAP_WORD_BITS-1:0]   wd_q;
  logic [WidxW-1:0]           widx_q, iw_q;
  logic                       wval_q, dirty_q;
  logic                       out_valid_q;
  bpa_pkg::rsp_t              out_q;

  logic                       mem_we, mem_re;
  logic [WidxW-1:0]           mem_waddr;
  logic [MAP_WORD_BITS-1:0]   mem_wdata, mem_rdata, init_mask;
  logic [WidxW-1:0]           pw;
  logic [BitW-1:0]            pb;
  logic                       hit, pbit, past_end;
  logic [31:0]                base, nres;
  logic [31:0]                tot_clip, res_clip;

  assign pw       = p_q[BitW +: WidxW];
  assign pb       = p_q[BitW-1:0];
  assign hit      = wval_q && (widx_q == pw);
  assign pbit     = wd_q[pb];
  assign past_end = 32'(p_q) >= 32'(active_q);

  assign tot_clip = (32'(total_cfg_q) > 32'(MAX_PAGE_COUNT)) ? 32'(MAX_PAGE_COUNT)
                                                              : 32'(total_cfg_q);
  assign res_clip = (32'(resv_cfg_q) > tot_clip) ? tot_clip : 32'(resv_cfg_q);

  // reserved pages of the word being swept at init
  always_comb begin
    base = 32'(iw_q) << BitW;
    nres = 32'(res_q) - base;
    if (32'(res_q) <= base) begin
      init_mask = '0;
    end else if (nres >= 32'(MAP_WORD_BITS)) begin
      init_mask = '1;
    end else begin
      init_mask = ~({MAP_WORD_BITS{1'b1}} << nres[BitW-1:0]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = widx_q;
    mem_wdata = wd_q;
    mem_re    = 1'b0;
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = iw_q;
        mem_wdata = init_mask;
      end
      S_LOAD: begin
        mem_we = dirty_q;
        mem_re = 1'b1;
      end
      S_FLUSH: mem_we = dirty_q;
      default: ;
    endcase
  end

  bpa_map_ram #(
    .Depth(MapWords),
    .Width(MAP_WORD_BITS),
    .AW   (WidxW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(pw),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      total_cfg_q <= bpa_pkg::TotalReset;
      resv_cfg_q  <= bpa_pkg::ReservedReset;
      ready_q     <= 1'b0;
      active_q    <= '0;
      free_q      <= '0;
      hint_q      <= '0;
      wval_q      <= 1'b0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bpa_pkg::REG_TOTAL) begin
          total_cfg_q <= cfg_data_i;
        end else if (cfg_idx_i == bpa_pkg::REG_RESERVED) begin
          resv_cfg_q <= cfg_data_i;
        end
      end
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            stat_q  <= bpa_pkg::STAT_OK;
            addr_q  <= '0;
            state_q <= S_DONE;
            case (in_req_i.command)
              bpa_pkg::CMD_INIT: begin
                active_q <= CntW'(tot_clip);
                free_q   <= CntW'(tot_clip - res_clip);
                hint_q   <= CntW'(res_clip);
                res_q    <= CntW'(res_clip);
                ready_q  <= 1'b1;
                iw_q     <= '0;
                wval_q   <= 1'b0;
                dirty_q  <= 1'b0;
                state_q  <= S_INIT;
              end
              bpa_pkg::CMD_ALLOC: begin
                if (!ready_q) begin
                  stat_q <= bpa_pkg::STAT_NOT_INIT;
                end else if (in_req_i.count == '0) begin
                  stat_q <= bpa_pkg::STAT_ZERO_CNT;
                end else if (free_q == '0 || 32'(in_req_i.count) > 32'(free_q)) begin
                  stat_q <= bpa_pkg::STAT_NO_SPACE;
                end else begin
                  run_q   <= '0;
                  p_q     <= PtrW'(hint_q);
                  cnt_q   <= in_req_i.count;
                  state_q <= S_SCAN;
                end
              end
              bpa_pkg::CMD_FREE: begin
                if (!ready_q) begin
                  stat_q <= bpa_pkg::STAT_NOT_INIT;
                end else if (in_req_i.count == '0) begin
                  stat_q <= bpa_pkg::STAT_ZERO_CNT;
                end else if (in_req_i.address[PgSh-1:0] != '0) begin
                  stat_q <= bpa_pkg::STAT_UNALIGNED;
                end else begin
                  p_q     <= PtrW'(in_req_i.address[bpa_pkg::AddrW-1:PgSh]);
                  rem_q   <= in_req_i.count;
                  state_q <= S_FREE;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          if (iw_q == WidxW'(MapWords - 1)) begin
            state_q <= S_DONE;
          end else begin
            iw_q <= iw_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (past_end) begin
            stat_q  <= bpa_pkg::STAT_NO_SPACE;
            state_q <= S_FLUSH;
          end else if (!hit) begin
            ret_q   <= S_SCAN;
            state_q <= S_LOAD;
          end else if (pbit) begin
            run_q <= '0;
            p_q   <= p_q + 1'b1;
          end else if (32'(run_q) + 32'd1 == 32'(cnt_q)) begin
            // run found, start of the run is p + 1 - count
            p_q     <= p_q + 1'b1 - PtrW'(cnt_q);
            addr_q  <= bpa_pkg::AddrW'(32'(p_q + 1'b1 - PtrW'(cnt_q)) << PgSh);
            end_q   <= p_q;
            state_q <= S_MARK;
          end else begin
            run_q <= run_q + 1'b1;
            p_q   <= p_q + 1'b1;
          end
        end
        S_MARK: begin
          if (!hit) begin
            ret_q   <= S_MARK;
            state_q <= S_LOAD;
          end else begin
            wd_q[pb] <= 1'b1;
            dirty_q  <= 1'b1;
            if (p_q == end_q) begin
              free_q  <= free_q - CntW'(cnt_q);
              p_q     <= PtrW'(hint_q);
              state_q <= S_HINT;
            end else begin
              p_q <= p_q + 1'b1;
            end
          end
        end
        S_HINT: begin
          if (past_end) begin
            hint_q  <= CntW'(p_q);
            state_q <= S_FLUSH;
          end else if (!hit) begin
            ret_q   <= S_HINT;
            state_q <= S_LOAD;
          end else if (pbit) begin
            p_q <= p_q + 1'b1;
          end else begin
            hint_q  <= CntW'(p_q);
            state_q <= S_FLUSH;
          end
        end
        S_FREE: begin
          if (rem_q == '0) begin
            state_q <= S_FLUSH;
          end else if (past_end) begin
            if (stat_q == bpa_pkg::STAT_OK) stat_q <= bpa_pkg::STAT_RANGE;
            state_q <= S_FLUSH;
          end else if (!hit) begin
            ret_q   <= S_FREE;
            state_q <= S_LOAD;
          end else begin
            if (!pbit) begin
              if (stat_q == bpa_pkg::STAT_OK) stat_q <= bpa_pkg::STAT_DBL_FREE;
            end else begin
              wd_q[pb] <= 1'b0;
              dirty_q  <= 1'b1;
              free_q   <= free_q + 1'b1;
              if (32'(p_q) < 32'(hint_q)) hint_q <= CntW'(p_q);
            end
            p_q   <= p_q + 1'b1;
            rem_q <= rem_q - 1'b1;
          end
        end
        S_LOAD: begin
          // dirty word goes back while the new one is fetched
          widx_q  <= pw;
          wval_q  <= 1'b0;
          dirty_q <= 1'b0;
          state_q <= S_CAPT;
        end
        S_CAPT: begin
          wd_q    <= mem_rdata;
          wval_q  <= 1'b1;
          state_q <= ret_q;
        end
        S_FLUSH: begin
          dirty_q <= 1'b0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status         <= stat_q;
            out_q.result_address <= (stat_q == bpa_pkg::STAT_OK) ? addr_q : '0;
            out_q.free_count     <= bpa_pkg::CountW'(free_q);
            out_q.used_count     <= bpa_pkg::CountW'(active_q - free_q);
            out_q.page_total     <= bpa_pkg::CountW'(active_q);
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= 32'(active_q))
    else $error("free count above total");

  a_hint_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> 32'(hint_q) <= 32'(active_q))
    else $error("free hint beyond total");

  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |-> wval_q)
    else $error("dirty map word without valid copy");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != pw))
    else $error("map read and write hit the same word");

  a_capt_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (state_q == S_CAPT))
    else $error("map fetch lost");

endmodule
